[design/assert_macros.svh]
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a holds implies b holds on the same clock edge.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed: a implies b");

// Check that a holds implies b holds on the next clock edge.
`define ASSERT_IMPLY_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed: a implies b next cycle");

`endif

[design/i2cbe_pkg.sv]
package i2cbe_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned BIT_IDX_W = $clog2(BYTE_BITS);

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_ACK  = 3'd3,
    CMD_READ_BYTE = 3'd4,
    CMD_SEND_ACK  = 3'd5,
    CMD_STOP      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2,
    PH_3 = 2'd3
  } phase_e;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 ack_out;
    logic                 sda_in;
  } in_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 ack_in;
    logic                 cmd_ignored;
  } out_t;

endpackage

[design/i2c_master_bit_engine_unit.sv]
// I2C master bit engine: one input word per bus tick, one result word per tick.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): each word carries the
// command, the byte to send, the ack level to drive and the sampled SDA level.
// A command is taken only while the engine is idle; a nonzero command that
// arrives while busy is dropped and flagged in the result word.
// Output channel (out_valid_o / out_stall_i / out_word_o): each word gives the
// SCL and SDA levels after the tick, busy, done, the last received byte and ack.
//
// The path from the input register to the result register holds the whole
// per-tick step; a word is processed as it moves along it, and its result is
// presented from then on. One word per cycle is sustained while not stalled.
// When the receiver stalls, the result register holds, the input register
// fills, and in_stall_o rises until the result is taken; no word is lost.
// Reset clears both valid flags and puts the engine idle with SCL and SDA
// released, ack level 1 and received byte 0.
`include "assert_macros.svh"

module i2c_master_bit_engine_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  i2cbe_pkg::in_t  in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output i2cbe_pkg::out_t out_word_o
);

  logic            in_valid_q;
  i2cbe_pkg::in_t  in_q;
  logic            out_valid_q;
  i2cbe_pkg::out_t out_q;
  i2cbe_pkg::out_t res;
  logic            advance;
  logic            out_free;

  // Result register can take a new word when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  // Stall the input only while a word waits and cannot move on.
  assign in_stall_o = in_valid_q && !out_free;

  i2cbe_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .in_i   (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= advance;
      end
    end
  end

  // Payload registers: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `ASSERT_IMPLY_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `ASSERT_IMPLY(a_done_idle, clk_i, rst_ni, out_valid_q && out_q.done_res,
    !out_q.busy_res)
  `ASSERT_IMPLY_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q)

endmodule

[design/i2cbe_core.sv]
`include "assert_macros.svh"

module i2cbe_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  i2cbe_pkg::in_t  in_i,
  output i2cbe_pkg::out_t res_o
);

  localparam int unsigned BW = i2cbe_pkg::BYTE_BITS;
  localparam int unsigned IW = i2cbe_pkg::BIT_IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(BW - 1);

  i2cbe_pkg::cmd_e   active_q, active_d;
  i2cbe_pkg::phase_e sub_q, sub_d;
  logic [IW-1:0]     bit_q, bit_d;
  logic [BW-1:0]     shift_q, shift_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_q, ack_d;
  logic [BW-1:0]     rx_q, rx_d;
  logic              done, ignored, last_bit;
  logic              cmd_valid;

  assign cmd_valid = (in_i.cmd >= i2cbe_pkg::CMD_START) && (in_i.cmd <= i2cbe_pkg::CMD_STOP);

  always_comb begin
    active_d = active_q;
    sub_d    = sub_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    rx_d     = rx_q;
    done     = 1'b0;
    ignored  = 1'b0;
    last_bit = (bit_q == LAST_IDX);

    // Take a new command only while idle.
    if (active_q == i2cbe_pkg::CMD_NONE) begin
      if (cmd_valid) begin
        active_d = i2cbe_pkg::cmd_e'(in_i.cmd);
        sub_d    = i2cbe_pkg::PH_0;
        bit_d    = '0;
        last_bit = 1'b0;
        if (in_i.cmd == i2cbe_pkg::CMD_WRITE) begin
          shift_d = in_i.tx_byte;
        end else if (in_i.cmd == i2cbe_pkg::CMD_READ_BYTE) begin
          shift_d = '0;
        end
      end
    end else if (in_i.cmd != i2cbe_pkg::CMD_NONE) begin
      ignored = 1'b1;
    end

    unique case (active_d)
      i2cbe_pkg::CMD_START: begin
        unique case (sub_d)
          i2cbe_pkg::PH_0: begin scl_d = 1'b1; sub_d = i2cbe_pkg::PH_1; end
          i2cbe_pkg::PH_1: begin sda_d = 1'b1; sub_d = i2cbe_pkg::PH_2; end
          i2cbe_pkg::PH_2: begin sda_d = 1'b0; sub_d = i2cbe_pkg::PH_3; end
          default: begin scl_d = 1'b0; done = 1'b1; end
        endcase
      end
      i2cbe_pkg::CMD_WRITE: begin
        unique case (sub_d)
          i2cbe_pkg::PH_0: begin
            sda_d = shift_d[LAST_IDX - bit_d];
            sub_d = i2cbe_pkg::PH_1;
          end
          i2cbe_pkg::PH_1: begin scl_d = 1'b1; sub_d = i2cbe_pkg::PH_2; end
          default: begin
            scl_d = 1'b0;
            if (last_bit) begin
              done = 1'b1;
            end else begin
              bit_d = bit_d + 1'b1;
              sub_d = i2cbe_pkg::PH_0;
            end
          end
        endcase
      end
      i2cbe_pkg::CMD_READ_ACK: begin
        unique case (sub_d)
          i2cbe_pkg::PH_0: begin sda_d = 1'b1; sub_d = i2cbe_pkg::PH_1; end
          i2cbe_pkg::PH_1: begin scl_d = 1'b1; sub_d = i2cbe_pkg::PH_2; end
          default: begin ack_d = in_i.sda_in; scl_d = 1'b0; done = 1'b1; end
        endcase
      end
      i2cbe_pkg::CMD_READ_BYTE: begin
        unique case (sub_d)
          i2cbe_pkg::PH_0: begin sda_d = 1'b1; sub_d = i2cbe_pkg::PH_1; end
          i2cbe_pkg::PH_1: begin scl_d = 1'b1; sub_d = i2cbe_pkg::PH_2; end
          default: begin
            shift_d = {shift_d[BW-2:0], in_i.sda_in};
            scl_d   = 1'b0;
            if (last_bit) begin
              rx_d = shift_d;
              done = 1'b1;
            end else begin
              bit_d = bit_d + 1'b1;
              sub_d = i2cbe_pkg::PH_1;
            end
          end
        endcase
      end
      i2cbe_pkg::CMD_SEND_ACK: begin
        unique case (sub_d)
          i2cbe_pkg::PH_0: begin sda_d = in_i.ack_out; sub_d = i2cbe_pkg::PH_1; end
          i2cbe_pkg::PH_1: begin scl_d = 1'b1; sub_d = i2cbe_pkg::PH_2; end
          default: begin scl_d = 1'b0; done = 1'b1; end
        endcase
      end
      i2cbe_pkg::CMD_STOP: begin
        unique case (sub_d)
          i2cbe_pkg::PH_0: begin sda_d = 1'b0; sub_d = i2cbe_pkg::PH_1; end
          i2cbe_pkg::PH_1: begin scl_d = 1'b1; sub_d = i2cbe_pkg::PH_2; end
          default: begin sda_d = 1'b1; done = 1'b1; end
        endcase
      end
      default: begin
        active_d = i2cbe_pkg::CMD_NONE;
      end
    endcase

    // Drop back to idle on the last pin change of a command.
    if (done) begin
      active_d = i2cbe_pkg::CMD_NONE;
      sub_d    = i2cbe_pkg::PH_0;
      bit_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= i2cbe_pkg::CMD_NONE;
      sub_q    <= i2cbe_pkg::PH_0;
      bit_q    <= '0;
      shift_q  <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      ack_q    <= 1'b1;
      rx_q     <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      sub_q    <= sub_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ack_q    <= ack_d;
      rx_q     <= rx_d;
    end
  end

  assign res_o.scl_level   = scl_d;
  assign res_o.sda_level   = sda_d;
  assign res_o.busy_res    = (active_d != i2cbe_pkg::CMD_NONE);
  assign res_o.done_res    = done;
  assign res_o.rx_byte     = rx_d;
  assign res_o.ack_in      = ack_d;
  assign res_o.cmd_ignored = ignored;

  `ASSERT_IMPLY(a_idle_clean, clk_i, rst_ni, active_q == i2cbe_pkg::CMD_NONE,
    sub_q == i2cbe_pkg::PH_0 && bit_q == '0)
  `ASSERT_IMPLY(a_ph3_start_only, clk_i, rst_ni, sub_q == i2cbe_pkg::PH_3,
    active_q == i2cbe_pkg::CMD_START)
  `ASSERT_IMPLY(a_no_ignore_idle, clk_i, rst_ni,
    step_i && active_q == i2cbe_pkg::CMD_NONE, !ignored)
  `ASSERT_IMPLY(a_done_not_busy, clk_i, rst_ni, step_i && done,
    active_d == i2cbe_pkg::CMD_NONE)

endmodule
